// File: rtl/bsd_pkg.sv
// Shared types and constants for the byte-stuffing deframer.
`timescale 1ns / 1ps
package bsd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned MAX_RES    = 3;   // results one byte can cause
    localparam int unsigned RES_CNT_W  = 2;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_PTR_W    = 2;
    localparam int unsigned Q_LVL_W    = 3;
    localparam int unsigned M_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG_CHAR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CHAR = 8'd1;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h2F;  // '/'

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic [BYTE_W-1:0] frame_parity;
        logic              short_frame;
        logic              run_last;
    } result_t;

    typedef struct packed {
        logic [Q_LVL_W-1:0] level;
        logic               not_empty;
    } q_status_t;

endpackage

// File: rtl/bsd_resq.sv
// Small result queue: up to three writes per cycle, one read.
`timescale 1ns / 1ps
module bsd_resq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [bsd_pkg::RES_CNT_W-1:0]       wr_cnt,
    input  bsd_pkg::result_t                    wr_data [bsd_pkg::MAX_RES],
    input  logic                                pop,
    output bsd_pkg::result_t                    head,
    output bsd_pkg::q_status_t                  status
);

    bsd_pkg::result_t                  mem_reg [bsd_pkg::Q_DEPTH];
    logic [bsd_pkg::Q_PTR_W-1:0]       wr_ptr_reg;
    logic [bsd_pkg::Q_PTR_W-1:0]       rd_ptr_reg;
    logic [bsd_pkg::Q_LVL_W-1:0]       level_reg;
    logic [bsd_pkg::Q_LVL_W-1:0]       level_next;
    logic                              do_pop;

    assign do_pop = pop && (level_reg != '0);
    assign level_next = level_reg + bsd_pkg::Q_LVL_W'(wr_cnt)
                        - bsd_pkg::Q_LVL_W'(do_pop);

    always_ff @(posedge aclk) begin
        for (int k = 0; k < bsd_pkg::MAX_RES; k++) begin
            if (bsd_pkg::RES_CNT_W'(k) < wr_cnt) begin
                mem_reg[wr_ptr_reg + bsd_pkg::Q_PTR_W'(k)] <= wr_data[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + bsd_pkg::Q_PTR_W'(wr_cnt);
            rd_ptr_reg <= rd_ptr_reg + bsd_pkg::Q_PTR_W'(do_pop);
            level_reg  <= level_next;
        end
    end

    assign head             = mem_reg[rd_ptr_reg];
    assign status.level     = level_reg;
    assign status.not_empty = (level_reg != '0);

endmodule

// File: rtl/byte_stuffing_deframer.sv
// Byte-stuffing deframer: unescapes, strips frame flags, reports parity per frame.
// Results of a beat are registered in the result queue; the m_ side shows its head.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready
//   stays high; extra results must drain from the queue, and s_tready drops while the
//   four-entry result queue holds more than one result.
// Reset: aresetn (synchronous) empties the queue, clears frame state and sets
//   flag_char to '$' and escape_char to '/'.
`timescale 1ns / 1ps
module byte_stuffing_deframer (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsd_pkg::BYTE_W-1:0]         cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
    input  logic                               s_tuser,   // [0] decode_enable
    input  logic                               s_tlast,   // frame_end
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bsd_pkg::M_TDATA_W-1:0]      m_tdata,   // [7:0] out_byte,
                                                          // [15:8] frame_parity,
                                                          // [16] short_frame
    output logic                               m_tuser,   // [0] kind
    output logic                               m_tlast    // run_last
);

    logic [bsd_pkg::BYTE_W-1:0] flag_reg;
    logic [bsd_pkg::BYTE_W-1:0] escape_reg;

    logic                       esc_pend_reg,  esc_pend_next;
    logic [bsd_pkg::BYTE_W-1:0] held_reg,      held_next;
    logic                       held_vld_reg,  held_vld_next;
    logic [1:0]                 seen_reg,      seen_next;
    logic [bsd_pkg::BYTE_W-1:0] parity_reg,    parity_next;
    logic                       in_frame_reg,  in_frame_next;
    logic                       mode_reg,      mode_next;

    logic                         s_beat;
    logic [bsd_pkg::RES_CNT_W-1:0] res_cnt;
    bsd_pkg::result_t             res [bsd_pkg::MAX_RES];
    bsd_pkg::result_t             head;
    bsd_pkg::q_status_t           q_stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = (q_stat.level <= bsd_pkg::Q_LVL_W'(1));
    assign s_beat    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= bsd_pkg::FLAG_RESET;
            escape_reg <= bsd_pkg::ESCAPE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bsd_pkg::REG_FLAG_CHAR:   flag_reg   <= cfg_data;
                bsd_pkg::REG_ESCAPE_CHAR: escape_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-byte step: up to two characters go through the flag-dropping hold stage
    // in order; the third slot is used only for a trailing escape at frame end.
    always_comb begin
        logic                       mode;
        logic [2:0]                 push_v;
        logic [bsd_pkg::BYTE_W-1:0] push_c [3];
        logic [bsd_pkg::RES_CNT_W-1:0] n;

        mode          = in_frame_reg ? mode_reg : s_tuser;
        parity_next   = parity_reg ^ s_tdata;
        esc_pend_next = esc_pend_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        seen_next     = seen_reg;
        in_frame_next = 1'b1;
        mode_next     = mode;
        push_v        = '0;
        push_c[0]     = s_tdata;
        push_c[1]     = s_tdata;
        push_c[2]     = escape_reg;
        n             = '0;
        for (int k = 0; k < bsd_pkg::MAX_RES; k++) begin
            res[k] = '0;
        end

        if (mode) begin
            if (esc_pend_reg) begin
                esc_pend_next = 1'b0;
                if (s_tdata == flag_reg || s_tdata == escape_reg) begin
                    push_v[0] = 1'b1;
                end else begin
                    push_v[0] = 1'b1;
                    push_c[0] = escape_reg;
                    push_v[1] = 1'b1;
                end
            end else if (s_tdata == escape_reg) begin
                esc_pend_next = 1'b1;
            end else begin
                push_v[0] = 1'b1;
            end
            push_v[2] = s_tlast && esc_pend_next;
        end else begin
            res[0].kind     = bsd_pkg::KIND_DATA;
            res[0].out_byte = s_tdata;
            n               = 2'd1;
        end

        for (int k = 0; k < 3; k++) begin
            if (push_v[k]) begin
                if (seen_next == 2'd0) begin
                    seen_next = 2'd1;
                end else begin
                    if (held_vld_next) begin
                        res[n].kind     = bsd_pkg::KIND_DATA;
                        res[n].out_byte = held_next;
                        n               = n + 2'd1;
                    end
                    held_next     = push_c[k];
                    held_vld_next = 1'b1;
                    seen_next     = 2'd2;
                end
            end
        end

        if (s_tlast) begin
            res[n].kind         = bsd_pkg::KIND_END;
            res[n].frame_parity = parity_next;
            res[n].short_frame  = mode && (seen_next < 2'd2);
            res[n].run_last     = 1'b1;
            n                   = n + 2'd1;
            esc_pend_next       = 1'b0;
            held_next           = '0;
            held_vld_next       = 1'b0;
            seen_next           = 2'd0;
            parity_next         = '0;
            in_frame_next       = 1'b0;
            mode_next           = 1'b0;
        end
        res_cnt = s_beat ? n : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pend_reg <= 1'b0;
            held_reg     <= '0;
            held_vld_reg <= 1'b0;
            seen_reg     <= 2'd0;
            parity_reg   <= '0;
            in_frame_reg <= 1'b0;
            mode_reg     <= 1'b0;
        end else if (s_beat) begin
            esc_pend_reg <= esc_pend_next;
            held_reg     <= held_next;
            held_vld_reg <= held_vld_next;
            seen_reg     <= seen_next;
            parity_reg   <= parity_next;
            in_frame_reg <= in_frame_next;
            mode_reg     <= mode_next;
        end
    end

    bsd_resq u_resq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_cnt  (res_cnt),
        .wr_data (res),
        .pop     (m_tready),
        .head    (head),
        .status  (q_stat)
    );

    assign m_tvalid = q_stat.not_empty;
    assign m_tdata  = {7'd0, head.short_frame, head.frame_parity, head.out_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.run_last;

    a_level_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |-> q_stat.level <= bsd_pkg::Q_LVL_W'(1))
        else $error("input beat taken without room for its results");

    a_level_max: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.level <= bsd_pkg::Q_LVL_W'(bsd_pkg::Q_DEPTH))
        else $error("result queue overfilled");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bsd_pkg::KIND_DATA) |-> (m_tdata[16:8] == 9'd0 && !m_tlast))
        else $error("data beat carries end status fields");

    a_frame_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_tlast) |=> (!in_frame_reg && !esc_pend_reg && seen_reg == 2'd0))
        else $error("frame state not cleared after last beat");

endmodule

// File: tb/byte_stuffing_deframer_test.sv
// Self-checking bench for the byte-stuffing deframer: directed frames, then random frames.
`timescale 1ns / 1ps
module byte_stuffing_deframer_test;

    localparam int QUIET_LIMIT  = 1000;  // cycles with no beat anywhere
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 8;
    localparam int PHASE_BEATS  = 38;
    localparam int NUM_PHASES   = 6;
    localparam int NUM_ROWS     = 32;

    typedef enum logic { ROW_BEAT, ROW_REG } row_op_t;

    typedef struct packed {
        row_op_t           op;
        logic [7:0]        reg_idx;
        logic [7:0]        data;
        logic              en;
        logic              last;
        logic              typed;    // end result given in the row
        logic [7:0]        parity;
        logic              shrt;
    } row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bsd_pkg::BYTE_W-1:0]     cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bsd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    byte_stuffing_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // deframer mirror: registers and frame state
    logic [7:0] cur_flag   = bsd_pkg::FLAG_RESET;
    logic [7:0] cur_escape = bsd_pkg::ESCAPE_RESET;
    logic       esc_seen   = 1'b0;
    logic [7:0] hold_byte  = '0;
    logic       hold_ok    = 1'b0;
    logic [1:0] char_count = '0;
    logic [7:0] parity     = '0;
    logic       framing    = 1'b0;
    logic       decode_mode = 1'b0;

    bsd_pkg::result_t expected_results [$];

    int  errors       = 0;
    int  beats_in     = 0;
    int  results_seen = 0;
    int  frames_seen  = 0;
    int  reg_writes   = 0;
    bit  tx_idle      = 1'b1;
    bit  rx_idle      = 1'b1;
    int  hold_reqs    = 0;
    int  holds_done   = 0;
    int  quiet        = 0;

    // one unescaped character: the first of a frame is the opening flag, each
    // later one is held and releases the character held before it, if any
    task automatic take_char(input logic [7:0] c);
        bsd_pkg::result_t r;
        if (char_count == 2'd0) begin
            char_count = 2'd1;
        end else begin
            if (hold_ok) begin
                r = '0;
                r.kind = bsd_pkg::KIND_DATA;
                r.out_byte = hold_byte;
                expected_results = {expected_results, r};
            end
            hold_byte  = c;
            hold_ok    = 1'b1;
            char_count = 2'd2;
        end
    endtask

    task automatic deframe_beat(input logic [7:0] b, input logic en, input logic last);
        bsd_pkg::result_t r;
        logic             shrt;
        if (!framing) begin
            decode_mode = en;
            framing = 1'b1;
        end
        parity = parity ^ b;
        if (decode_mode) begin
            if (esc_seen) begin
                esc_seen = 1'b0;
                if (b == cur_flag || b == cur_escape) begin
                    take_char(b);
                end else begin
                    take_char(cur_escape);
                    take_char(b);
                end
            end else if (b == cur_escape) begin
                esc_seen = 1'b1;
            end else begin
                take_char(b);
            end
        end else begin
            r = '0;
            r.kind = bsd_pkg::KIND_DATA;
            r.out_byte = b;
            expected_results = {expected_results, r};
        end
        if (last) begin
            shrt = 1'b0;
            if (decode_mode) begin
                // a dangling escape counts as a plain character
                if (esc_seen)
                    take_char(cur_escape);
                shrt = (char_count < 2'd2);
            end
            r = '0;
            r.kind = bsd_pkg::KIND_END;
            r.frame_parity = parity;
            r.short_frame = shrt;
            r.run_last = 1'b1;
            expected_results = {expected_results, r};
            esc_seen    = 1'b0;
            hold_byte   = '0;
            hold_ok     = 1'b0;
            char_count  = '0;
            parity      = '0;
            framing     = 1'b0;
            decode_mode = 1'b0;
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic en, input logic last);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= en;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        beats_in++;
        deframe_beat(b, en, last);
    endtask

    // registers change only once the block has gone quiet
    task automatic write_reg(input logic [bsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == bsd_pkg::REG_FLAG_CHAR)
            cur_flag = value;
        else if (idx == bsd_pkg::REG_ESCAPE_CHAR)
            cur_escape = value;
    endtask

    // biased towards the two special bytes so escapes turn up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: pick_byte = cur_flag;
            1: pick_byte = cur_escape;
            default: pick_byte = 8'($urandom);
        endcase
    endfunction

    task automatic send_frame();
        logic [7:0] bytes [$];
        logic [7:0] p;
        logic       en;
        int         shape;
        int         len;
        shape = $urandom_range(0, 9);
        en = 1'b1;
        if (shape < 6) begin
            // well-formed stuffed frame
            bytes = {bytes, cur_flag};
            len = $urandom_range(0, 6);
            repeat (len) begin
                p = pick_byte();
                if (p == cur_flag || p == cur_escape)
                    bytes = {bytes, cur_escape};
                bytes = {bytes, p};
            end
            bytes = {bytes, cur_flag};
        end else if (shape < 8) begin
            // noise: stray escapes, missing flags, trailing escape
            len = $urandom_range(1, 6);
            repeat (len) bytes = {bytes, pick_byte()};
        end else begin
            en = 1'b0;
            len = $urandom_range(1, 5);
            repeat (len) bytes = {bytes, 8'($urandom)};
        end
        // enable only matters on the first byte; the rest get noise
        foreach (bytes[i])
            send_beat(bytes[i], (i == 0) ? en : 1'($urandom_range(0, 1)),
                      i == bytes.size() - 1);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        bsd_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser == bsd_pkg::KIND_END)
                frames_seen++;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: tdata %0h tuser %0b tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("out_byte", want.out_byte, m_tdata[7:0]);
                check_field("frame_parity", want.frame_parity, m_tdata[15:8]);
                check_field("short_frame", want.short_frame, m_tdata[16]);
                check_field("run_last", want.run_last, m_tlast);
            end
        end
    end

    // result side back-pressure
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_reqs != holds_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                         quiet, expected_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        row_t       steps [NUM_ROWS];
        logic [7:0] v;
        int         phase_end;

        steps = '{
            // one-byte pass-through frame, all ones
            '{ROW_BEAT, 8'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0},
            // one-byte decode frame, zero byte: short
            '{ROW_BEAT, 8'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1},
            // escape before flag, before escape, before other byte
            '{ROW_BEAT, 8'd0, 8'h24, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h24, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h2F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h2F, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h2F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h78, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h24, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
            // trailing escape
            '{ROW_BEAT, 8'd0, 8'h24, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h2F, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
            // two flags only: no data, not short
            '{ROW_BEAT, 8'd0, 8'h24, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h24, 1'b1, 1'b1, 1'b1, 8'h00, 1'b0},
            // escape changed mid-frame
            '{ROW_BEAT, 8'd0, 8'h24, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_REG, bsd_pkg::REG_ESCAPE_CHAR, 8'h23, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h23, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h24, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h5A, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
            // register extremes
            '{ROW_REG, bsd_pkg::REG_FLAG_CHAR, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_REG, bsd_pkg::REG_ESCAPE_CHAR, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0},
            // flag and escape the same byte
            '{ROW_REG, bsd_pkg::REG_FLAG_CHAR, 8'h7E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_REG, bsd_pkg::REG_ESCAPE_CHAR, 8'h7E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h7E, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h7E, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h55, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
            '{ROW_BEAT, 8'd0, 8'h7E, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (steps[i].op == ROW_REG) begin
                write_reg(steps[i].reg_idx, steps[i].data);
            end else begin
                send_beat(steps[i].data, steps[i].en, steps[i].last);
                if (steps[i].typed) begin
                    expected_results[expected_results.size() - 1].frame_parity =
                        steps[i].parity;
                    expected_results[expected_results.size() - 1].short_frame =
                        steps[i].shrt;
                end
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    write_reg(bsd_pkg::REG_FLAG_CHAR, bsd_pkg::FLAG_RESET);
                    write_reg(bsd_pkg::REG_ESCAPE_CHAR, bsd_pkg::ESCAPE_RESET);
                end
                2: begin
                    write_reg(bsd_pkg::REG_FLAG_CHAR, 8'hFF);
                    write_reg(bsd_pkg::REG_ESCAPE_CHAR, 8'h00);
                end
                3: begin
                    v = 8'($urandom);
                    write_reg(bsd_pkg::REG_FLAG_CHAR, v);
                    write_reg(bsd_pkg::REG_ESCAPE_CHAR, v);
                end
                default: begin
                    write_reg(bsd_pkg::REG_FLAG_CHAR, 8'($urandom));
                    write_reg(bsd_pkg::REG_ESCAPE_CHAR, 8'($urandom));
                end
            endcase
            if (ph == 1)
                hold_reqs++;
            if (ph == NUM_PHASES - 1) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            phase_end = beats_in + PHASE_BEATS;
            while (beats_in < phase_end)
                send_frame();
        end

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("%0d input beats, %0d result beats over %0d frames checked",
                 beats_in, results_seen, frames_seen);
        $display("%0d register writes across %0d flag/escape settings",
                 reg_writes, NUM_PHASES + 3);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/bsd_pkg.sv
rtl/bsd_resq.sv
rtl/byte_stuffing_deframer.sv
tb/byte_stuffing_deframer_test.sv
